// ===== hdl/ffcha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffcha_pkg
// Shared constants and types for the first-fit checked heap allocator.
// ----------------------------------------------------------------------------
package ffcha_pkg;

    localparam int ARENA_QUANTA  = 4096;
    localparam int QUANTUM_BYTES = 16;
    localparam int HEADER_QUANTA = 3;

    localparam int IDX_W     = $clog2(ARENA_QUANTA);
    localparam int QB_LOG    = $clog2(QUANTUM_BYTES);
    localparam int OFF_W     = 16;
    localparam int SIZE_W    = 16;
    localparam int REQ_W     = 32;
    localparam int NEED_W    = REQ_W + 1 - QB_LOG;
    localparam int NX_W      = IDX_W + 2;
    localparam int FIRST_OFF = HEADER_QUANTA * QUANTUM_BYTES;

    typedef enum logic [1:0] {
        ST_ACTIVE   = 2'd0,
        ST_INACTIVE = 2'd1,
        ST_FREED    = 2'd2
    } t_cst;

    typedef struct packed {
        logic               is_head;
        t_cst               st;
        logic               has_prev;
        logic [IDX_W-1:0]   allot;
        logic [IDX_W-1:0]   prev;
        logic [SIZE_W-1:0]  size;
    } t_chunk;

    localparam int CHUNK_W = $bits(t_chunk);

    localparam t_chunk CHUNK_INIT = '{
        is_head:  1'b1,
        st:       ST_INACTIVE,
        has_prev: 1'b0,
        allot:    IDX_W'(ARENA_QUANTA - HEADER_QUANTA),
        prev:     '0,
        size:     '0
    };

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_ZERO      = 3'd1,
        STS_NO_SPACE  = 3'd2,
        STS_NULL_FREE = 3'd3,
        STS_NOT_HEAP  = 3'd4,
        STS_UNALIGNED = 3'd5,
        STS_DOUBLE    = 3'd6,
        STS_NOT_ALLOC = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        SK_NONE,
        SK_ZERO,
        SK_GRANT,
        SK_REFUSE,
        SK_RELEASE
    } t_stat_kind;

    typedef struct packed {
        t_stat_kind         kind;
        logic [REQ_W-1:0]   bytes;
    } t_stat_cmd;

endpackage

// ===== hdl/ffcha_ram.sv =====
// ----------------------------------------------------------------------------
// ffcha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffcha_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/ffcha_stats.sv =====
// ----------------------------------------------------------------------------
// ffcha_stats
// Saturating live and lifetime counters, updated at most once per finished request.
// ----------------------------------------------------------------------------
module ffcha_stats (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ffcha_pkg::t_stat_cmd i_cmd,
    output logic [12:0]          o_live_count,
    output logic [16:0]          o_live_bytes,
    output logic [31:0]          o_grant_count,
    output logic [47:0]          o_grant_bytes,
    output logic [31:0]          o_refuse_count,
    output logic [47:0]          o_refuse_bytes
);

    logic [12:0] r_lc;
    logic [16:0] r_lb;
    logic [31:0] r_gc;
    logic [47:0] r_gb;
    logic [31:0] r_rc;
    logic [47:0] r_rb;

    logic [12:0] lc_inc, lc_dec;
    logic [16:0] lb_add, lb_dec;
    logic [32:0] lb_sum;
    logic [31:0] gc_inc, rc_inc;
    logic [48:0] gb_sum, rb_sum;
    logic [47:0] gb_add, rb_add;

    assign lc_inc = (&r_lc) ? r_lc : r_lc + 13'd1;
    assign lc_dec = (r_lc == '0) ? r_lc : r_lc - 13'd1;
    assign lb_sum = 33'(r_lb) + 33'(i_cmd.bytes);
    assign lb_add = (lb_sum > 33'(17'h1FFFF)) ? '1 : lb_sum[16:0];
    assign lb_dec = (33'(i_cmd.bytes) > 33'(r_lb)) ? '0 : r_lb - i_cmd.bytes[16:0];
    assign gc_inc = (&r_gc) ? r_gc : r_gc + 32'd1;
    assign rc_inc = (&r_rc) ? r_rc : r_rc + 32'd1;
    assign gb_sum = {1'b0, r_gb} + 49'(i_cmd.bytes);
    assign rb_sum = {1'b0, r_rb} + 49'(i_cmd.bytes);
    assign gb_add = gb_sum[48] ? '1 : gb_sum[47:0];
    assign rb_add = rb_sum[48] ? '1 : rb_sum[47:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc <= '0;
            r_lb <= '0;
            r_gc <= '0;
            r_gb <= '0;
            r_rc <= '0;
            r_rb <= '0;
        end else begin
            unique case (i_cmd.kind)
                ffcha_pkg::SK_ZERO: begin
                    r_gc <= gc_inc;
                end
                ffcha_pkg::SK_GRANT: begin
                    r_lc <= lc_inc;
                    r_lb <= lb_add;
                    r_gc <= gc_inc;
                    r_gb <= gb_add;
                end
                ffcha_pkg::SK_REFUSE: begin
                    r_rc <= rc_inc;
                    r_rb <= rb_add;
                end
                ffcha_pkg::SK_RELEASE: begin
                    r_lc <= lc_dec;
                    r_lb <= lb_dec;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_live_count   = r_lc;
    assign o_live_bytes   = r_lb;
    assign o_grant_count  = r_gc;
    assign o_grant_bytes  = r_gb;
    assign o_refuse_count = r_rc;
    assign o_refuse_bytes = r_rb;

endmodule

// ===== hdl/first_fit_checked_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_checked_heap_allocator
// First-fit chunk allocator with checked free and neighbor coalescing.
// ----------------------------------------------------------------------------
// allocate walks the chunk chain one header at a time from the first chunk, a zero-size
//   request skips it; a free checks its header, then merges a free successor, then a free predecessor
// one request at a time: each header access goes through the one chunk RAM
// reset: synchronous; after reset a clearing pass sweeps all 4096 entries of the chunk
//   table, and no request is taken until it ends
module first_fit_checked_heap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [31:0] i_req_bytes,
    input  logic [15:0] i_free_offset,
    input  logic        i_free_is_null,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_payload_offset,
    output logic [12:0] o_active_count,
    output logic [16:0] o_active_bytes,
    output logic [31:0] o_total_count,
    output logic [47:0] o_total_bytes,
    output logic [31:0] o_fail_count,
    output logic [47:0] o_fail_bytes
);

    localparam int IDX_W  = ffcha_pkg::IDX_W;
    localparam int OFF_W  = ffcha_pkg::OFF_W;
    localparam int QB_LOG = ffcha_pkg::QB_LOG;
    localparam int NX_W   = ffcha_pkg::NX_W;
    localparam int NEED_W = ffcha_pkg::NEED_W;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE,
        S_A_RD, S_A_CHK, S_A_LNK, S_A_FIN,
        S_F_RD, S_F_HD, S_F_NX, S_F_NL, S_F_PV, S_F_PC, S_F_Z, S_F_PL,
        S_FIN, S_OUT
    } t_state;

    t_state                     r_state, n_state;
    ffcha_pkg::t_op             r_op, n_op;
    logic [31:0]                r_sz, n_sz;
    logic [NEED_W-1:0]          r_need, n_need;
    logic [IDX_W-1:0]           r_h, n_h;
    logic [IDX_W-1:0]           r_t, n_t;
    logic [IDX_W-1:0]           r_p, n_p;
    logic [IDX_W-1:0]           r_take, n_take;
    logic [IDX_W-1:0]           r_clr, n_clr;
    ffcha_pkg::t_chunk          r_cur, n_cur;
    logic [ffcha_pkg::SIZE_W-1:0] r_rel, n_rel;
    ffcha_pkg::t_status         r_status, n_status;
    logic [OFF_W-1:0]           r_payload, n_payload;
    logic [OFF_W-1:0]           r_heap_top, n_heap_top;

    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr, mem_raddr;
    ffcha_pkg::t_chunk          mem_wdata;
    logic [ffcha_pkg::CHUNK_W-1:0] mem_rdata;
    ffcha_pkg::t_chunk          rd;
    logic                       rd_free;

    ffcha_pkg::t_stat_cmd       stat_cmd;

    // shared next-header adder
    logic [IDX_W-1:0]           nx_base, nx_allot;
    logic [NX_W-1:0]            nx_sum;
    logic                       nx_in;

    logic [NEED_W-1:0]          need_in;
    logic [IDX_W-1:0]           split_idx, split_diff, pay_idx;
    logic [IDX_W:0]             end_idx, end_m1;
    logic [OFF_W-1:0]           last_off;

    ffcha_ram #(
        .W (ffcha_pkg::CHUNK_W),
        .D (ffcha_pkg::ARENA_QUANTA)
    ) u_chunks (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ffcha_stats u_stats (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (stat_cmd),
        .o_live_count   (o_active_count),
        .o_live_bytes   (o_active_bytes),
        .o_grant_count  (o_total_count),
        .o_grant_bytes  (o_total_bytes),
        .o_refuse_count (o_fail_count),
        .o_refuse_bytes (o_fail_bytes)
    );

    assign rd      = ffcha_pkg::t_chunk'(mem_rdata);
    assign rd_free = rd.is_head &&
                     (rd.st == ffcha_pkg::ST_INACTIVE || rd.st == ffcha_pkg::ST_FREED);

    always_comb begin
        unique case (r_state)
            S_F_NX: begin
                nx_base  = r_t;
                nx_allot = rd.allot;
            end
            S_F_Z: begin
                nx_base  = r_h;
                nx_allot = r_cur.allot;
            end
            default: begin
                nx_base  = r_h;
                nx_allot = rd.allot;
            end
        endcase
    end

    assign nx_sum = NX_W'(nx_base) + NX_W'(ffcha_pkg::HEADER_QUANTA) + NX_W'(nx_allot);
    assign nx_in  = nx_sum < NX_W'(ffcha_pkg::ARENA_QUANTA);

    assign need_in = NEED_W'((33'(i_req_bytes) + 33'(ffcha_pkg::QUANTUM_BYTES - 1))
                             >> QB_LOG);

    assign split_diff = rd.allot - r_need[IDX_W-1:0];
    assign split_idx  = r_h + IDX_W'(ffcha_pkg::HEADER_QUANTA) + r_need[IDX_W-1:0];
    assign pay_idx    = r_h + IDX_W'(ffcha_pkg::HEADER_QUANTA);
    assign end_idx    = {1'b0, pay_idx} + {1'b0, r_take};
    assign end_m1     = end_idx - (IDX_W+1)'(1);
    assign last_off   = OFF_W'({end_m1, {QB_LOG{1'b1}}});

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_sz       = r_sz;
        n_need     = r_need;
        n_h        = r_h;
        n_t        = r_t;
        n_p        = r_p;
        n_take     = r_take;
        n_clr      = r_clr;
        n_cur      = r_cur;
        n_rel      = r_rel;
        n_status   = r_status;
        n_payload  = r_payload;
        n_heap_top = r_heap_top;
        mem_we     = 1'b0;
        mem_waddr  = r_h;
        mem_wdata  = r_cur;
        mem_raddr  = r_h;
        stat_cmd   = '{kind: ffcha_pkg::SK_NONE, bytes: '0};

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (r_clr == '0) ? ffcha_pkg::CHUNK_INIT : '0;
                n_clr     = r_clr + IDX_W'(1);
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_op      = ffcha_pkg::t_op'(i_op);
                    n_sz      = i_req_bytes;
                    n_need    = need_in;
                    n_payload = '0;
                    if (ffcha_pkg::t_op'(i_op) == ffcha_pkg::OP_ALLOC) begin
                        if (i_req_bytes == '0) begin
                            n_status = ffcha_pkg::STS_ZERO;
                            n_state  = S_FIN;
                        end else begin
                            n_h     = '0;
                            n_state = S_A_RD;
                        end
                    end else begin
                        n_state = S_FIN;
                        priority if (i_free_is_null) begin
                            n_status = ffcha_pkg::STS_NULL_FREE;
                        end else if (i_free_offset < OFF_W'(ffcha_pkg::FIRST_OFF) ||
                                     i_free_offset >= r_heap_top) begin
                            n_status = ffcha_pkg::STS_NOT_HEAP;
                        end else if (i_free_offset[QB_LOG-1:0] != '0) begin
                            n_status = ffcha_pkg::STS_UNALIGNED;
                        end else begin
                            n_h     = i_free_offset[OFF_W-1:QB_LOG]
                                      - IDX_W'(ffcha_pkg::HEADER_QUANTA);
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD: begin
                mem_raddr = r_h;
                n_state   = S_A_CHK;
            end
            S_A_CHK: begin
                priority if (!rd.is_head) begin
                    n_status = ffcha_pkg::STS_NO_SPACE;
                    n_state  = S_FIN;
                end else if (rd_free && r_need <= NEED_W'(rd.allot)) begin
                    n_cur = rd;
                    if (split_diff >= IDX_W'(ffcha_pkg::HEADER_QUANTA + 1)) begin
                        // carve the remainder into a new inactive chunk
                        n_take    = r_need[IDX_W-1:0];
                        mem_we    = 1'b1;
                        mem_waddr = split_idx;
                        mem_wdata = '{is_head: 1'b1, st: ffcha_pkg::ST_INACTIVE,
                                      has_prev: 1'b1,
                                      allot: split_diff - IDX_W'(ffcha_pkg::HEADER_QUANTA),
                                      prev: r_h, size: '0};
                        if (nx_in) begin
                            mem_raddr = nx_sum[IDX_W-1:0];
                            n_t       = nx_sum[IDX_W-1:0];
                            n_p       = split_idx;
                            n_state   = S_A_LNK;
                        end else begin
                            n_state = S_A_FIN;
                        end
                    end else begin
                        n_take  = rd.allot;
                        n_state = S_A_FIN;
                    end
                end else if (!nx_in) begin
                    n_status = ffcha_pkg::STS_NO_SPACE;
                    n_state  = S_FIN;
                end else begin
                    n_h     = nx_sum[IDX_W-1:0];
                    n_state = S_A_RD;
                end
            end
            S_A_LNK: begin
                mem_we             = 1'b1;
                mem_waddr          = r_t;
                mem_wdata          = rd;
                mem_wdata.prev     = r_p;
                mem_wdata.has_prev = 1'b1;
                n_state            = S_A_FIN;
            end
            S_A_FIN: begin
                mem_we          = 1'b1;
                mem_waddr       = r_h;
                mem_wdata       = r_cur;
                mem_wdata.st    = ffcha_pkg::ST_ACTIVE;
                mem_wdata.allot = r_take;
                mem_wdata.size  = r_sz[ffcha_pkg::SIZE_W-1:0];
                n_payload       = OFF_W'({pay_idx, {QB_LOG{1'b0}}});
                if (last_off > r_heap_top) begin
                    n_heap_top = last_off;
                end
                n_status = ffcha_pkg::STS_OK;
                n_state  = S_FIN;
            end
            S_F_RD: begin
                mem_raddr = r_h;
                n_state   = S_F_HD;
            end
            S_F_HD: begin
                priority if (rd.is_head && rd.st == ffcha_pkg::ST_FREED) begin
                    n_status = ffcha_pkg::STS_DOUBLE;
                    n_state  = S_FIN;
                end else if (!rd.is_head || rd.st != ffcha_pkg::ST_ACTIVE) begin
                    n_status = ffcha_pkg::STS_NOT_ALLOC;
                    n_state  = S_FIN;
                end else begin
                    n_cur    = rd;
                    n_cur.st = ffcha_pkg::ST_FREED;
                    n_rel    = rd.size;
                    if (nx_in) begin
                        mem_raddr = nx_sum[IDX_W-1:0];
                        n_t       = nx_sum[IDX_W-1:0];
                        n_state   = S_F_NX;
                    end else begin
                        n_state = S_F_PV;
                    end
                end
            end
            S_F_NX: begin
                if (rd_free) begin
                    // absorb the free successor
                    n_cur.allot = r_cur.allot + rd.allot + IDX_W'(ffcha_pkg::HEADER_QUANTA);
                    mem_we      = 1'b1;
                    mem_waddr   = r_t;
                    mem_wdata   = '0;
                    if (nx_in) begin
                        mem_raddr = nx_sum[IDX_W-1:0];
                        n_t       = nx_sum[IDX_W-1:0];
                        n_state   = S_F_NL;
                    end else begin
                        n_state = S_F_PV;
                    end
                end else begin
                    n_state = S_F_PV;
                end
            end
            S_F_NL: begin
                mem_we             = 1'b1;
                mem_waddr          = r_t;
                mem_wdata          = rd;
                mem_wdata.prev     = r_h;
                mem_wdata.has_prev = 1'b1;
                n_state            = S_F_PV;
            end
            S_F_PV: begin
                if (r_cur.has_prev) begin
                    mem_raddr = r_cur.prev;
                    n_p       = r_cur.prev;
                    n_state   = S_F_PC;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_h;
                    mem_wdata = r_cur;
                    n_status  = ffcha_pkg::STS_OK;
                    n_state   = S_FIN;
                end
            end
            S_F_PC: begin
                if (rd_free) begin
                    // fold this chunk into the free predecessor
                    mem_we          = 1'b1;
                    mem_waddr       = r_p;
                    mem_wdata       = rd;
                    mem_wdata.allot = rd.allot + IDX_W'(ffcha_pkg::HEADER_QUANTA)
                                      + r_cur.allot;
                    n_state         = S_F_Z;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_h;
                    mem_wdata = r_cur;
                    n_status  = ffcha_pkg::STS_OK;
                    n_state   = S_FIN;
                end
            end
            S_F_Z: begin
                mem_we    = 1'b1;
                mem_waddr = r_h;
                mem_wdata = '0;
                if (nx_in) begin
                    mem_raddr = nx_sum[IDX_W-1:0];
                    n_t       = nx_sum[IDX_W-1:0];
                    n_state   = S_F_PL;
                end else begin
                    n_status = ffcha_pkg::STS_OK;
                    n_state  = S_FIN;
                end
            end
            S_F_PL: begin
                mem_we             = 1'b1;
                mem_waddr          = r_t;
                mem_wdata          = rd;
                mem_wdata.prev     = r_p;
                mem_wdata.has_prev = 1'b1;
                n_status           = ffcha_pkg::STS_OK;
                n_state            = S_FIN;
            end
            S_FIN: begin
                priority if (r_op == ffcha_pkg::OP_ALLOC && r_status == ffcha_pkg::STS_OK) begin
                    stat_cmd = '{kind: ffcha_pkg::SK_GRANT, bytes: r_sz};
                end else if (r_op == ffcha_pkg::OP_ALLOC &&
                             r_status == ffcha_pkg::STS_ZERO) begin
                    stat_cmd = '{kind: ffcha_pkg::SK_ZERO, bytes: '0};
                end else if (r_op == ffcha_pkg::OP_ALLOC &&
                             r_status == ffcha_pkg::STS_NO_SPACE) begin
                    stat_cmd = '{kind: ffcha_pkg::SK_REFUSE, bytes: r_sz};
                end else if (r_op == ffcha_pkg::OP_FREE &&
                             r_status == ffcha_pkg::STS_OK) begin
                    stat_cmd = '{kind: ffcha_pkg::SK_RELEASE, bytes: 32'(r_rel)};
                end else begin
                    stat_cmd = '{kind: ffcha_pkg::SK_NONE, bytes: '0};
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_heap_top <= OFF_W'(ffcha_pkg::FIRST_OFF);
            r_status   <= ffcha_pkg::STS_OK;
            r_payload  <= '0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_heap_top <= n_heap_top;
            r_status   <= n_status;
            r_payload  <= n_payload;
        end
        r_op   <= n_op;
        r_sz   <= n_sz;
        r_need <= n_need;
        r_h    <= n_h;
        r_t    <= n_t;
        r_p    <= n_p;
        r_take <= n_take;
        r_cur  <= n_cur;
        r_rel  <= n_rel;
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_status         = r_status;
    assign o_payload_offset = r_payload;

    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request accepted while a result is pending");

    a_payload_only_on_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ffcha_pkg::STS_OK) |-> (o_payload_offset == '0))
        else $error("payload offset set on a failed request");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_active_count <= 13'(ffcha_pkg::ARENA_QUANTA)))
        else $error("live allocation count out of range");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) |=> !o_valid)
        else $error("result delivered twice");

endmodule

// ===== dv/first_fit_checked_heap_allocator_chk.sv =====
// ----------------------------------------------------------------------------
// first_fit_checked_heap_allocator_chk
// Watches both channels, keeps its own chunk chain and counters, predicts each
// response and compares it field by field with what the allocator returns.
// ----------------------------------------------------------------------------
module first_fit_checked_heap_allocator_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic        i_op,
    input  logic [31:0] i_req_bytes,
    input  logic [15:0] i_free_offset,
    input  logic        i_free_is_null,
    input  logic        i_out_valid,
    input  logic        i_stall_out,
    input  logic [2:0]  i_status,
    input  logic [15:0] i_payload_offset,
    input  logic [12:0] i_active_count,
    input  logic [16:0] i_active_bytes,
    input  logic [31:0] i_total_count,
    input  logic [47:0] i_total_bytes,
    input  logic [31:0] i_fail_count,
    input  logic [47:0] i_fail_bytes,
    output int          o_errors,
    output int          o_pending,
    output int          o_grants
);

    localparam int ARENA_Q  = ffcha_pkg::ARENA_QUANTA;
    localparam int HDR_Q    = ffcha_pkg::HEADER_QUANTA;
    localparam int QUANT_B  = ffcha_pkg::QUANTUM_BYTES;

    typedef struct packed {
        ffcha_pkg::t_status status;
        logic [15:0] payload;
        logic [12:0] act_cnt;
        logic [16:0] act_bytes;
        logic [31:0] tot_cnt;
        logic [47:0] tot_bytes;
        logic [31:0] fail_cnt;
        logic [47:0] fail_bytes;
    } t_resp;

    localparam longint M13 = 64'h1FFF;
    localparam longint M17 = 64'h1FFFF;
    localparam longint M32 = 64'hFFFF_FFFF;
    localparam longint M48 = 64'hFFFF_FFFF_FFFF;

    // shadow chunk chain, indexed by header quantum
    logic            hd    [ARENA_Q];
    ffcha_pkg::t_cst cst   [ARENA_Q];
    logic            hp    [ARENA_Q];
    int              allot [ARENA_Q];
    int              prv   [ARENA_Q];
    longint          sz    [ARENA_Q];

    longint live_n, live_b, grant_n, grant_b, refuse_n, refuse_b, top_off;
    t_resp  expected_q[$];

    function automatic longint sat_add(longint v, longint a, longint mx);
        return (v > mx || a > mx - v) ? mx : v + a;
    endfunction

    function automatic longint floor_sub(longint v, longint a);
        return (a > v) ? 0 : v - a;
    endfunction

    function automatic bit is_open(ffcha_pkg::t_cst s);
        return s == ffcha_pkg::ST_INACTIVE || s == ffcha_pkg::ST_FREED;
    endfunction

    function automatic int next_hdr(int h);
        return h + HDR_Q + allot[h];
    endfunction

    function automatic void clear_hdr(int h);
        hd[h] = 0; cst[h] = ffcha_pkg::ST_ACTIVE; hp[h] = 0; allot[h] = 0;
        prv[h] = 0; sz[h] = 0;
    endfunction

    function automatic void relink(int h);
        int n;
        n = next_hdr(h);
        if (n < ARENA_Q) begin
            prv[n] = h;
            hp[n]  = 1;
        end
    endfunction

    function automatic void arena_reset();
        for (int i = 0; i < ARENA_Q; i++) clear_hdr(i);
        hd[0] = 1; cst[0] = ffcha_pkg::ST_INACTIVE; allot[0] = ARENA_Q - HDR_Q;
        live_n = 0; live_b = 0; grant_n = 0; grant_b = 0; refuse_n = 0; refuse_b = 0;
        top_off = ffcha_pkg::FIRST_OFF;
    endfunction

    function automatic ffcha_pkg::t_status alloc_chunk(longint req,
                                                       output logic [15:0] pay);
        longint need, last;
        int h, steps, hit, take, r;
        pay = '0;
        if (req == 0) begin
            grant_n = sat_add(grant_n, 1, M32);
            return ffcha_pkg::STS_ZERO;
        end
        need = (req + QUANT_B - 1) / QUANT_B;
        h = 0; steps = 0; hit = ARENA_Q;
        while (h < ARENA_Q && steps < ARENA_Q) begin
            if (!hd[h]) break;
            if (is_open(cst[h]) && need <= allot[h]) begin
                hit = h;
                break;
            end
            h = next_hdr(h);
            steps++;
        end
        if (hit >= ARENA_Q) begin
            refuse_n = sat_add(refuse_n, 1, M32);
            refuse_b = sat_add(refuse_b, req, M48);
            return ffcha_pkg::STS_NO_SPACE;
        end
        take = int'(need);
        if (allot[hit] - need < HDR_Q + 1) begin
            take = allot[hit];
        end else begin
            // split the tail into a fresh unused chunk
            r = hit + HDR_Q + int'(need);
            hd[r] = 1; cst[r] = ffcha_pkg::ST_INACTIVE; hp[r] = 1; prv[r] = hit;
            allot[r] = allot[hit] - int'(need) - HDR_Q; sz[r] = 0;
            relink(r);
        end
        cst[hit] = ffcha_pkg::ST_ACTIVE; allot[hit] = take; sz[hit] = req;
        pay = 16'((hit + HDR_Q) * QUANT_B);
        live_n  = sat_add(live_n, 1, M13);
        live_b  = sat_add(live_b, req, M17);
        grant_n = sat_add(grant_n, 1, M32);
        grant_b = sat_add(grant_b, req, M48);
        last = (hit + HDR_Q) * QUANT_B + take * QUANT_B - 1;
        if (last > top_off) top_off = last;
        return ffcha_pkg::STS_OK;
    endfunction

    function automatic ffcha_pkg::t_status free_chunk(longint off, logic is_null);
        int h, n, p;
        if (is_null) return ffcha_pkg::STS_NULL_FREE;
        if (off < ffcha_pkg::FIRST_OFF || off >= top_off) return ffcha_pkg::STS_NOT_HEAP;
        if (off % QUANT_B != 0) return ffcha_pkg::STS_UNALIGNED;
        h = int'(off / QUANT_B) - HDR_Q;
        if (h >= ARENA_Q) return ffcha_pkg::STS_NOT_ALLOC;
        if (hd[h] && cst[h] == ffcha_pkg::ST_FREED) return ffcha_pkg::STS_DOUBLE;
        if (!hd[h] || cst[h] != ffcha_pkg::ST_ACTIVE) return ffcha_pkg::STS_NOT_ALLOC;
        cst[h] = ffcha_pkg::ST_FREED;
        live_n = floor_sub(live_n, 1);
        live_b = floor_sub(live_b, sz[h]);
        n = next_hdr(h);
        if (n < ARENA_Q && hd[n] && is_open(cst[n])) begin
            allot[h] = allot[h] + allot[n] + HDR_Q;
            clear_hdr(n);
            relink(h);
        end
        if (hp[h] && prv[h] < ARENA_Q) begin
            p = prv[h];
            if (hd[p] && is_open(cst[p])) begin
                allot[p] = allot[p] + HDR_Q + allot[h];
                clear_hdr(h);
                relink(p);
            end
        end
        return ffcha_pkg::STS_OK;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_resp r, e;
        if (!i_rst_n) begin
            arena_reset();
            expected_q.delete();
        end else begin
            if (i_valid && !i_stall_in) begin
                if (ffcha_pkg::t_op'(i_op) == ffcha_pkg::OP_ALLOC)
                    r.status = alloc_chunk(longint'(i_req_bytes), r.payload);
                else begin
                    r.payload = '0;
                    r.status  = free_chunk(longint'(i_free_offset), i_free_is_null);
                end
                r.act_cnt = 13'(live_n);   r.act_bytes = 17'(live_b);
                r.tot_cnt = 32'(grant_n);  r.tot_bytes = 48'(grant_b);
                r.fail_cnt = 32'(refuse_n); r.fail_bytes = 48'(refuse_b);
                expected_q.push_back(r);
            end
            if (i_out_valid && !i_stall_out) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("response with nothing pending", i_status, 0);
                end else begin
                    e = expected_q.pop_front();
                    if (i_status == ffcha_pkg::STS_OK && e.payload != 0) o_grants++;
                    if (i_status != e.status)
                        report_mismatch("status", i_status, e.status);
                    if (i_payload_offset != e.payload)
                        report_mismatch("payload_offset", i_payload_offset, e.payload);
                    if (i_active_count != e.act_cnt)
                        report_mismatch("active_count", i_active_count, e.act_cnt);
                    if (i_active_bytes != e.act_bytes)
                        report_mismatch("active_bytes", i_active_bytes, e.act_bytes);
                    if (i_total_count != e.tot_cnt)
                        report_mismatch("total_count", i_total_count, e.tot_cnt);
                    if (i_total_bytes != e.tot_bytes)
                        report_mismatch("total_bytes", i_total_bytes, e.tot_bytes);
                    if (i_fail_count != e.fail_cnt)
                        report_mismatch("fail_count", i_fail_count, e.fail_cnt);
                    if (i_fail_bytes != e.fail_bytes)
                        report_mismatch("fail_bytes", i_fail_bytes, e.fail_bytes);
                end
            end
        end
        o_pending <= expected_q.size();
    end

    initial begin
        o_errors  = 0;
        o_grants  = 0;
        o_pending = 0;
    end

endmodule

// ===== dv/first_fit_checked_heap_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_checked_heap_allocator_tb
// Drives directed and random allocate/free requests with random idle bursts on
// both sides; a checker beside the allocator predicts and compares responses.
// ----------------------------------------------------------------------------
module first_fit_checked_heap_allocator_tb;

    localparam int N_RANDOM    = 1400;
    localparam int QUIET_TAIL  = 200;
    localparam int STALL_LIMIT = 60000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_op;
    logic [31:0] i_req_bytes;
    logic [15:0] i_free_offset;
    logic        i_free_is_null;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [15:0] o_payload_offset;
    logic [12:0] o_active_count;
    logic [16:0] o_active_bytes;
    logic [31:0] o_total_count;
    logic [47:0] o_total_bytes;
    logic [31:0] o_fail_count;
    logic [47:0] o_fail_bytes;

    int          errors, pending, grants;
    bit          gaps_on;
    int          sent, quiet_cnt, stall_left;
    bit          stall_burst;
    logic [15:0] live_pool[$];
    logic [15:0] freed_pool[$];

    first_fit_checked_heap_allocator DUT (.*);

    first_fit_checked_heap_allocator_chk u_chk (
        .i_clk, .i_rst_n, .i_valid,
        .i_stall_in       (o_stall),
        .i_op, .i_req_bytes, .i_free_offset, .i_free_is_null,
        .i_out_valid      (o_valid),
        .i_stall_out      (i_stall),
        .i_status         (o_status),
        .i_payload_offset (o_payload_offset),
        .i_active_count   (o_active_count),
        .i_active_bytes   (o_active_bytes),
        .i_total_count    (o_total_count),
        .i_total_bytes    (o_total_bytes),
        .i_fail_count     (o_fail_count),
        .i_fail_bytes     (o_fail_bytes),
        .o_errors         (errors),
        .o_pending        (pending),
        .o_grants         (grants)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // response side stall bursts, and tracking of granted offsets for frees
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
            stall_left <= 0;
            stall_burst <= 0;
        end else begin
            if (o_valid && !i_stall && o_status == ffcha_pkg::STS_OK &&
                o_payload_offset != 0)
                live_pool.push_back(o_payload_offset);
            if (!gaps_on) begin
                i_stall <= 0;
            end else if (stall_left == 0) begin
                stall_burst <= $urandom_range(0, 2) == 0;
                stall_left  <= $urandom_range(1, 10);
                i_stall     <= 0;
            end else begin
                stall_left <= stall_left - 1;
                i_stall    <= stall_burst;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= STALL_LIMIT) begin
            $display("watchdog expired with %0d responses pending", pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_request(ffcha_pkg::t_op op, logic [31:0] req, logic [15:0] off,
                                logic nul);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid        <= 1;
        i_op           <= op;
        i_req_bytes    <= req;
        i_free_offset  <= off;
        i_free_is_null <= nul;
        do @(posedge i_clk); while (o_stall);
        sent++;
    endtask

    task automatic random_request();
        int          pick, k;
        logic [31:0] req;
        logic [15:0] off;
        pick = $urandom_range(0, 99);
        if (live_pool.size() > 80) pick = pick / 2 + 50;
        if (pick < 50) begin
            k = $urandom_range(0, 19);
            if (k < 13)      req = $urandom_range(1, 256);
            else if (k < 17) req = $urandom_range(1, 6000);
            else if (k == 17) req = 0;
            else             req = $urandom();
            send_request(ffcha_pkg::OP_ALLOC, req, 16'($urandom()), 1'($urandom()));
        end else if (pick < 85 && live_pool.size() > 0) begin
            k = $urandom_range(0, live_pool.size() - 1);
            off = live_pool[k];
            live_pool.delete(k);
            freed_pool.push_back(off);
            if (freed_pool.size() > 32) void'(freed_pool.pop_front());
            send_request(ffcha_pkg::OP_FREE, $urandom(), off, 1'b0);
        end else begin
            k = $urandom_range(0, 4);
            if (k == 0 && freed_pool.size() > 0)
                off = freed_pool[$urandom_range(0, freed_pool.size() - 1)];
            else if (k == 1)
                off = 16'($urandom_range(ffcha_pkg::FIRST_OFF / ffcha_pkg::QUANTUM_BYTES,
                                         4095) * ffcha_pkg::QUANTUM_BYTES);
            else
                off = 16'($urandom());
            send_request(ffcha_pkg::OP_FREE, $urandom(), off,
                         k == 4 ? 1'($urandom()) : 1'b0);
        end
    endtask

    initial begin
        int limit;
        i_rst_n = 0; i_valid = 0; i_op = 0; i_req_bytes = 0;
        i_free_offset = 0; i_free_is_null = 0;
        gaps_on = 1; sent = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: edges of the fields and each error path
        send_request(ffcha_pkg::OP_FREE,  32'd0, 16'd48, 1'b0);          // before any grant
        send_request(ffcha_pkg::OP_FREE,  32'd0, 16'd0, 1'b1);           // null
        send_request(ffcha_pkg::OP_ALLOC, 32'd0, 16'hFFFF, 1'b1);        // zero size
        send_request(ffcha_pkg::OP_ALLOC, 32'hFFFF_FFFF, 16'd0, 1'b0);   // no space
        send_request(ffcha_pkg::OP_ALLOC, 32'd65489, 16'd0, 1'b0);       // just past arena
        send_request(ffcha_pkg::OP_ALLOC, 32'd1, 16'd0, 1'b0);
        send_request(ffcha_pkg::OP_ALLOC, 32'd16, 16'd0, 1'b0);
        send_request(ffcha_pkg::OP_ALLOC, 32'd17, 16'd0, 1'b0);
        send_request(ffcha_pkg::OP_ALLOC, 32'd100, 16'd0, 1'b0);
        send_request(ffcha_pkg::OP_FREE,  32'd0, 16'd0, 1'b0);           // below heap
        send_request(ffcha_pkg::OP_FREE,  32'd0, 16'hFFFF, 1'b0);        // above heap top
        send_request(ffcha_pkg::OP_FREE,  32'd0, 16'd49, 1'b0);          // unaligned
        send_request(ffcha_pkg::OP_FREE,  32'd0, 16'd64, 1'b0);          // inside a header
        send_request(ffcha_pkg::OP_FREE,  32'd0, 16'd112, 1'b0);         // middle chunk
        send_request(ffcha_pkg::OP_FREE,  32'd0, 16'd112, 1'b0);         // double free
        send_request(ffcha_pkg::OP_FREE,  32'd0, 16'd48, 1'b0);          // merges forward
        send_request(ffcha_pkg::OP_FREE,  32'd0, 16'd48, 1'b0);          // merged or double
        send_request(ffcha_pkg::OP_ALLOC, 32'd40000, 16'd0, 1'b0);
        send_request(ffcha_pkg::OP_ALLOC, 32'd30000, 16'd0, 1'b0);       // no space
        send_request(ffcha_pkg::OP_ALLOC, 32'd65488, 16'd0, 1'b0);       // no space, live
        while (pending != 0 || live_pool.size() < 3) @(posedge i_clk);
        while (live_pool.size() > 0) begin
            send_request(ffcha_pkg::OP_FREE, 32'd0, live_pool.pop_front(), 1'b0);
        end
        send_request(ffcha_pkg::OP_ALLOC, 32'd65488, 16'd0, 1'b0);       // whole arena
        while (pending != 0 || live_pool.size() < 1) @(posedge i_clk);
        send_request(ffcha_pkg::OP_FREE,  32'd0, live_pool.pop_front(), 1'b0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - QUIET_TAIL) gaps_on = 0;
            random_request();
        end
        i_valid <= 0;
        // let the pending count see the last accepted request
        @(posedge i_clk);

        limit = 0;
        while (pending != 0 && limit < STALL_LIMIT) begin
            @(posedge i_clk);
            limit++;
        end
        repeat (20) @(posedge i_clk);
        $display("sent %0d requests, %0d granted allocations seen", sent, grants);
        $display("final live allocations %0d, refused %0d", o_active_count, o_fail_count);
        if (errors == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
